[rtl/link_connection_manager_fsm_defines.svh]
// Assertion macros used by the checker file.
`ifndef LINK_CONNECTION_MANAGER_FSM_DEFINES_SVH
`define LINK_CONNECTION_MANAGER_FSM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("link manager check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("link manager check failed");

`endif

[rtl/lcm_pkg.sv]
package lcm_pkg;

  localparam int EVENT_W = 5;
  localparam int STATE_W = 4;
  localparam int CMD_W   = 3;

  // Event codes; anything above EV_ERASE_DONE is ignored.
  localparam logic [EVENT_W-1:0] EV_HOST_READY  = 5'd0;
  localparam logic [EVENT_W-1:0] EV_RADIO_SYNC  = 5'd1;
  localparam logic [EVENT_W-1:0] EV_STOR_BOND   = 5'd2;
  localparam logic [EVENT_W-1:0] EV_STOR_NOBOND = 5'd3;
  localparam logic [EVENT_W-1:0] EV_KNOWN_FOUND = 5'd4;
  localparam logic [EVENT_W-1:0] EV_PAIR_FOUND  = 5'd5;
  localparam logic [EVENT_W-1:0] EV_CONN_OK     = 5'd6;
  localparam logic [EVENT_W-1:0] EV_CONN_FAIL   = 5'd7;
  localparam logic [EVENT_W-1:0] EV_HID_FAIL    = 5'd8;
  localparam logic [EVENT_W-1:0] EV_HID_READY   = 5'd9;
  localparam logic [EVENT_W-1:0] EV_DISCONNECT  = 5'd10;
  localparam logic [EVENT_W-1:0] EV_HOST_RESET  = 5'd11;
  localparam logic [EVENT_W-1:0] EV_BOND_BAD    = 5'd12;
  localparam logic [EVENT_W-1:0] EV_META_FAULT  = 5'd13;
  localparam logic [EVENT_W-1:0] EV_BTN_SHORT   = 5'd14;
  localparam logic [EVENT_W-1:0] EV_BTN_LONG    = 5'd15;
  localparam logic [EVENT_W-1:0] EV_ERASE_DONE  = 5'd16;

  // Connection state codes as seen on the result port.
  localparam logic [STATE_W-1:0] LS_BOOT       = 4'd0;
  localparam logic [STATE_W-1:0] LS_HOSTREADY  = 4'd1;
  localparam logic [STATE_W-1:0] LS_KNOWNSCAN  = 4'd2;
  localparam logic [STATE_W-1:0] LS_PAIRSCAN   = 4'd3;
  localparam logic [STATE_W-1:0] LS_CONNECTING = 4'd4;
  localparam logic [STATE_W-1:0] LS_RECONNECT  = 4'd5;
  localparam logic [STATE_W-1:0] LS_CONNECTED  = 4'd6;
  localparam logic [STATE_W-1:0] LS_RECOVERY   = 4'd7;
  localparam logic [STATE_W-1:0] LS_ERASING    = 4'd8;

  // Radio commands.
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_KNOWN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAIR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FAST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ERASE = 3'd5;

  // One event handed from the input register to the core.
  typedef struct packed {
    logic               fire;
    logic [EVENT_W-1:0] code;
  } lcm_step_t;

endpackage

[rtl/lcm_core.sv]
module lcm_core
  import lcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lcm_step_t          step,
  output logic [STATE_W-1:0] current_state,
  output logic [CMD_W-1:0]   radio_command,
  output logic               release_keys,
  output logic               state_written
);

  typedef enum logic [STATE_W-1:0] {
    ST_BOOT       = LS_BOOT,
    ST_HOSTREADY  = LS_HOSTREADY,
    ST_KNOWNSCAN  = LS_KNOWNSCAN,
    ST_PAIRSCAN   = LS_PAIRSCAN,
    ST_CONNECTING = LS_CONNECTING,
    ST_RECONNECT  = LS_RECONNECT,
    ST_CONNECTED  = LS_CONNECTED,
    ST_RECOVERY   = LS_RECOVERY,
    ST_ERASING    = LS_ERASING
  } state_t;

  state_t           state_r, state_nxt;
  logic             host_r, host_nxt;
  logic             sync_r, sync_nxt;
  logic             stor_r, stor_nxt;
  logic             bond_r, bond_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic             rel_r, rel_nxt;
  logic             wr_r, wr_nxt;
  logic             gate;

  always_comb begin
    state_nxt = state_r;
    host_nxt  = host_r;
    sync_nxt  = sync_r;
    stor_nxt  = stor_r;
    bond_nxt  = bond_r;
    cmd_nxt   = CMD_NONE;
    rel_nxt   = 1'b0;
    wr_nxt    = 1'b0;
    gate      = 1'b0;

    unique case (step.code)
      EV_HOST_READY: begin
        host_nxt = 1'b1;
        gate     = 1'b1;
      end
      EV_RADIO_SYNC: begin
        sync_nxt = 1'b1;
        gate     = 1'b1;
      end
      EV_STOR_BOND: begin
        stor_nxt = 1'b1;
        bond_nxt = 1'b1;
        gate     = 1'b1;
      end
      EV_STOR_NOBOND: begin
        stor_nxt = 1'b1;
        bond_nxt = 1'b0;
        gate     = 1'b1;
      end
      EV_KNOWN_FOUND, EV_PAIR_FOUND, EV_CONN_OK: begin
        state_nxt = ST_CONNECTING;
        wr_nxt    = 1'b1;
      end
      EV_CONN_FAIL, EV_HID_FAIL, EV_DISCONNECT, EV_BTN_SHORT: begin
        // short press is dropped while in recovery
        if (step.code != EV_BTN_SHORT || state_r != ST_RECOVERY) begin
          state_nxt = bond_r ? ST_RECONNECT : ST_PAIRSCAN;
          cmd_nxt   = bond_r ? CMD_FAST : CMD_PAIR;
          wr_nxt    = 1'b1;
          rel_nxt   = (step.code == EV_DISCONNECT);
        end
      end
      EV_HID_READY: begin
        state_nxt = ST_CONNECTED;
        wr_nxt    = 1'b1;
      end
      EV_HOST_RESET: begin
        sync_nxt  = 1'b0;
        state_nxt = ST_HOSTREADY;
        cmd_nxt   = CMD_STOP;
        rel_nxt   = 1'b1;
        wr_nxt    = 1'b1;
      end
      EV_BOND_BAD: begin
        state_nxt = ST_RECOVERY;
        cmd_nxt   = CMD_STOP;
        rel_nxt   = 1'b1;
        wr_nxt    = 1'b1;
      end
      EV_META_FAULT: begin
        state_nxt = bond_r ? ST_KNOWNSCAN : ST_PAIRSCAN;
        cmd_nxt   = bond_r ? CMD_KNOWN : CMD_PAIR;
        wr_nxt    = 1'b1;
      end
      EV_BTN_LONG: begin
        state_nxt = ST_ERASING;
        cmd_nxt   = CMD_ERASE;
        rel_nxt   = 1'b1;
        wr_nxt    = 1'b1;
      end
      EV_ERASE_DONE: begin
        bond_nxt  = 1'b0;
        stor_nxt  = 1'b1;
        state_nxt = ST_PAIRSCAN;
        cmd_nxt   = CMD_PAIR;
        wr_nxt    = 1'b1;
      end
      default: begin
      end
    endcase

    // Start-up gate: boot steps to hostready, then, once sync and storage are in, on to a scan in the same pass.
    if (gate && host_nxt) begin
      if (state_nxt == ST_BOOT) begin
        state_nxt = ST_HOSTREADY;
        wr_nxt    = 1'b1;
      end
      if (sync_nxt && stor_nxt && state_nxt == ST_HOSTREADY) begin
        state_nxt = bond_nxt ? ST_KNOWNSCAN : ST_PAIRSCAN;
        cmd_nxt   = bond_nxt ? CMD_KNOWN : CMD_PAIR;
        wr_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
      host_r  <= 1'b0;
      sync_r  <= 1'b0;
      stor_r  <= 1'b0;
      bond_r  <= 1'b0;
    end else if (step.fire) begin
      state_r <= state_nxt;
      host_r  <= host_nxt;
      sync_r  <= sync_nxt;
      stor_r  <= stor_nxt;
      bond_r  <= bond_nxt;
    end
    if (step.fire) begin
      cmd_r <= cmd_nxt;
      rel_r <= rel_nxt;
      wr_r  <= wr_nxt;
    end
  end

  assign current_state = state_r;
  assign radio_command = cmd_r;
  assign release_keys  = rel_r;
  assign state_written = wr_r;

endmodule

[rtl/link_connection_manager_fsm.sv]
// Link connection manager.
// Input channel: in_event_code with in_valid / in_stall. One event per
// transfer; codes above the bond-erase-complete event leave everything
// unchanged but still produce a result.
// Result channel: out_current_state, out_radio_command, out_release_keys and
// out_state_written with out_valid / out_stall; exactly one result per event,
// in order.
// Path: an accepted event moves from the input register into the result
// register, written with the state update, which raises out_valid.
// Throughput: one event per cycle while the result is not stalled; the single
// state update per cycle in the core sets that figure.
// A stalled result holds; the input register still takes one more event
// while the result waits, and in_stall rises once both stages are full.
// Reset (rst_n low, synchronous) returns the state to boot, clears the four
// flags and empties both stages.
module link_connection_manager_fsm
  import lcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [EVENT_W-1:0] in_event_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STATE_W-1:0] out_current_state,
  output logic [CMD_W-1:0]   out_radio_command,
  output logic               out_release_keys,
  output logic               out_state_written
);

  logic               in_vld_r;
  logic [EVENT_W-1:0] in_code_r;
  logic               out_vld_r;
  logic               advance;
  logic               take;
  lcm_step_t          step;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign take     = in_valid && !in_stall;

  assign step.fire = in_vld_r && advance;
  assign step.code = in_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        in_vld_r <= 1'b1;
      end else if (step.fire) begin
        in_vld_r <= 1'b0;
      end
      if (step.fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (take) begin
      in_code_r <= in_event_code;
    end
  end

  lcm_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .current_state (out_current_state),
    .radio_command (out_radio_command),
    .release_keys  (out_release_keys),
    .state_written (out_state_written)
  );

  assign out_valid = out_vld_r;

endmodule

[rtl/lcm_checker.sv]
`include "link_connection_manager_fsm_defines.svh"

module lcm_checker
  import lcm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STATE_W-1:0] out_current_state,
  input logic [CMD_W-1:0]   out_radio_command,
  input logic               out_release_keys,
  input logic               out_state_written
);

  // a stalled result holds
  `LCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_current_state) && $stable(out_radio_command) && $stable(out_release_keys) && $stable(out_state_written))

  // no command and no key release without a state write
  `LCM_ASSERT_NOW(a_quiet, out_valid && !out_state_written, out_radio_command == CMD_NONE && !out_release_keys)

  // bond erase always lands in erasing with keys released
  `LCM_ASSERT_NOW(a_erase, out_valid && out_radio_command == CMD_ERASE, out_current_state == LS_ERASING && out_release_keys)

  // a stop command goes with hostready or recovery
  `LCM_ASSERT_NOW(a_stop, out_valid && out_radio_command == CMD_STOP, (out_current_state == LS_HOSTREADY || out_current_state == LS_RECOVERY) && out_release_keys)

endmodule

bind link_connection_manager_fsm lcm_checker u_lcm_checker (.*);

[test/tb.sv]
import lcm_pkg::*;

typedef struct packed {
  logic [STATE_W-1:0] cur_state;
  logic [CMD_W-1:0]   radio_cmd;
  logic               drop_keys;
  logic               wrote;
} link_result_t;

// Tracks the connection state and flags, and holds the results still owed by the block.
class link_scoreboard;
  logic [STATE_W-1:0] link_st;
  bit                 host_up;
  bit                 radio_up;
  bit                 store_up;
  bit                 bonded;
  link_result_t       step_res;
  link_result_t       awaited[$];
  int unsigned        errors;

  function new();
    link_st  = LS_BOOT;
    host_up  = 1'b0;
    radio_up = 1'b0;
    store_up = 1'b0;
    bonded   = 1'b0;
    errors   = 0;
  endfunction

  function void move_to(logic [STATE_W-1:0] nxt, logic [CMD_W-1:0] cmd);
    link_st = nxt;
    step_res.wrote = 1'b1;
    step_res.radio_cmd = cmd;
  endfunction

  // Boot goes to hostready first; the same pass may then carry on into a scan.
  function void startup_gate();
    if (!host_up) return;
    if (link_st == LS_BOOT) move_to(LS_HOSTREADY, CMD_NONE);
    if (!radio_up || !store_up) return;
    if (link_st != LS_HOSTREADY) return;
    if (bonded) move_to(LS_KNOWNSCAN, CMD_KNOWN);
    else move_to(LS_PAIRSCAN, CMD_PAIR);
  endfunction

  function void retry_link();
    if (bonded) move_to(LS_RECONNECT, CMD_FAST);
    else move_to(LS_PAIRSCAN, CMD_PAIR);
  endfunction

  function void note_event(logic [EVENT_W-1:0] code);
    step_res = '0;
    step_res.radio_cmd = CMD_NONE;
    case (code)
      EV_HOST_READY: begin
        host_up = 1'b1;
        startup_gate();
      end
      EV_RADIO_SYNC: begin
        radio_up = 1'b1;
        startup_gate();
      end
      EV_STOR_BOND: begin
        store_up = 1'b1;
        bonded = 1'b1;
        startup_gate();
      end
      EV_STOR_NOBOND: begin
        store_up = 1'b1;
        bonded = 1'b0;
        startup_gate();
      end
      EV_KNOWN_FOUND, EV_PAIR_FOUND, EV_CONN_OK: move_to(LS_CONNECTING, CMD_NONE);
      EV_CONN_FAIL, EV_HID_FAIL: retry_link();
      EV_HID_READY: move_to(LS_CONNECTED, CMD_NONE);
      EV_DISCONNECT: begin
        step_res.drop_keys = 1'b1;
        retry_link();
      end
      // no gate pass here, and the radio must sync again
      EV_HOST_RESET: begin
        radio_up = 1'b0;
        step_res.drop_keys = 1'b1;
        move_to(LS_HOSTREADY, CMD_STOP);
      end
      EV_BOND_BAD: begin
        step_res.drop_keys = 1'b1;
        move_to(LS_RECOVERY, CMD_STOP);
      end
      EV_META_FAULT: begin
        if (bonded) move_to(LS_KNOWNSCAN, CMD_KNOWN);
        else move_to(LS_PAIRSCAN, CMD_PAIR);
      end
      EV_BTN_SHORT: begin
        if (link_st != LS_RECOVERY) retry_link();
      end
      EV_BTN_LONG: begin
        step_res.drop_keys = 1'b1;
        move_to(LS_ERASING, CMD_ERASE);
      end
      EV_ERASE_DONE: begin
        bonded = 1'b0;
        store_up = 1'b1;
        move_to(LS_PAIRSCAN, CMD_PAIR);
      end
      default: ;
    endcase
    step_res.cur_state = link_st;
    awaited.push_back(step_res);
  endfunction

  function void check_result(link_result_t got);
    link_result_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: current_state %0d radio_command %0d", got.cur_state,
             got.radio_cmd);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.cur_state !== want.cur_state) begin
      $error("current_state: expected %0d, got %0d", want.cur_state, got.cur_state);
      errors++;
    end
    if (got.radio_cmd !== want.radio_cmd) begin
      $error("radio_command: expected %0d, got %0d", want.radio_cmd, got.radio_cmd);
      errors++;
    end
    if (got.drop_keys !== want.drop_keys) begin
      $error("release_keys: expected %0d, got %0d", want.drop_keys, got.drop_keys);
      errors++;
    end
    if (got.wrote !== want.wrote) begin
      $error("state_written: expected %0d, got %0d", want.wrote, got.wrote);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;
  localparam int TAIL_CYCLES = 8;
  localparam logic [EVENT_W-1:0] EV_FIRST_UNUSED = EV_ERASE_DONE + 5'd1;
  localparam logic [EVENT_W-1:0] EV_TOP_CODE = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [EVENT_W-1:0] in_event_code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STATE_W-1:0] out_current_state;
  logic [CMD_W-1:0]   out_radio_command;
  logic               out_release_keys;
  logic               out_state_written;

  link_scoreboard board;
  bit             rx_quiet = 1'b0;
  int unsigned    hold_requests = 0;
  int unsigned    cycle_count = 0;

  // Early sync, gate double write, host reset, short press in recovery, unknown codes.
  logic [EVENT_W-1:0] opening_seq [23] = '{
    EV_TOP_CODE, EV_RADIO_SYNC, EV_STOR_BOND, EV_HOST_READY, EV_HOST_READY,
    EV_PAIR_FOUND, EV_CONN_OK, EV_HID_READY, EV_DISCONNECT, EV_CONN_FAIL,
    EV_HID_FAIL, EV_KNOWN_FOUND, EV_HOST_RESET, EV_STOR_NOBOND, EV_RADIO_SYNC,
    EV_BOND_BAD, EV_BTN_SHORT, EV_META_FAULT, EV_BTN_SHORT, EV_BTN_LONG,
    EV_ERASE_DONE, EV_FIRST_UNUSED, EV_HOST_READY
  };

  link_connection_manager_fsm dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_event_code    (in_event_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_current_state(out_current_state),
    .out_radio_command(out_radio_command),
    .out_release_keys (out_release_keys),
    .out_state_written(out_state_written)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    link_result_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_event(in_event_code);
      if (out_valid && !out_stall) begin
        seen.cur_state = out_current_state;
        seen.radio_cmd = out_radio_command;
        seen.drop_keys = out_release_keys;
        seen.wrote = out_state_written;
        board.check_result(seen);
      end
    end
  end

  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_quiet) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // Hold the event until the block takes it.
  task automatic send_event(input logic [EVENT_W-1:0] code);
    in_valid <= 1'b1;
    in_event_code <= code;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle(input bit gaps);
    if (gaps && $urandom_range(0, 99) < 20) idle_for($urandom_range(1, 3));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
  endtask

  function automatic logic [EVENT_W-1:0] pick_event();
    logic [EVENT_W-1:0] code;
    if ($urandom_range(0, 9) == 0) begin
      code = EVENT_W'($urandom_range(EV_FIRST_UNUSED, EV_TOP_CODE));
    end else begin
      code = EVENT_W'($urandom_range(EV_HOST_READY, EV_ERASE_DONE));
    end
    return code;
  endfunction

  // Unknown codes are sent too but do not advance the count.
  task automatic send_random(input int unsigned count, input bit gaps);
    int unsigned sent;
    logic [EVENT_W-1:0] code;
    sent = 0;
    while (sent < count) begin
      code = pick_event();
      send_event(code);
      if (code <= EV_ERASE_DONE) sent++;
      maybe_idle(gaps);
    end
  endtask

  initial begin : stimulus
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening_seq[i]) begin
      send_event(opening_seq[i]);
      maybe_idle(1'b1);
    end
    send_random(350, 1'b1);
    rx_quiet = 1'b1;
    send_random(260, 1'b0);
    rx_quiet = 1'b0;
    // long receiver hold-off while events keep coming: both stages fill
    hold_requests++;
    send_random(60, 1'b0);
    wait_drained();
    send_random(340, 1'b1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/lcm_pkg.sv
rtl/lcm_core.sv
rtl/link_connection_manager_fsm.sv
rtl/lcm_checker.sv
test/tb.sv
